// ----- design/plob_pkg.sv -----
`timescale 1ns / 1ps
package plob_pkg;

  localparam logic [1:0] FN_ADD      = 2'd0;
  localparam logic [1:0] FN_CANCEL   = 2'd1;
  localparam logic [1:0] FN_MODIFY   = 2'd2;
  localparam logic [1:0] FN_RESERVED = 2'd3;

  // Widest level index that any supported book depth needs.
  localparam int LVL_MAXW = 16;

  // Configuration port: one register, selected by paddr[2].
  localparam int         CFG_AW           = 3;
  localparam logic       REG_LOWEST_PRICE = 1'b0;

  typedef struct packed {
    logic [1:0]          func;
    logic [11:0]         order_id;
    logic                id_ok;
    logic                side;
    logic [LVL_MAXW-1:0] lvl;
    logic                in_range;
    logic                qty_zero;
    logic [23:0]         qty;
  } cmd_t;

endpackage

// ----- design/plob_if.sv -----
`timescale 1ns / 1ps
interface plob_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [11:0] order_id;
  logic        side;
  logic [31:0] price;
  logic [23:0] quantity;

  modport source(output valid, func, order_id, side, price, quantity, input ready);
  modport sink(input valid, func, order_id, side, price, quantity, output ready);
endinterface

interface plob_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic        bid_valid;
  logic [31:0] best_bid_price;
  logic [35:0] best_bid_quantity;
  logic        ask_valid;
  logic [31:0] best_ask_price;
  logic [35:0] best_ask_quantity;
  logic [35:0] bid_side_shares;
  logic [35:0] ask_side_shares;

  modport source(output valid, ok, bid_valid, best_bid_price, best_bid_quantity, ask_valid,
                 best_ask_price, best_ask_quantity, bid_side_shares, ask_side_shares,
                 input ready);
  modport sink(input valid, ok, bid_valid, best_bid_price, best_bid_quantity, ask_valid,
               best_ask_price, best_ask_quantity, bid_side_shares, ask_side_shares,
               output ready);
endinterface

// ----- design/plob_front.sv -----
`timescale 1ns / 1ps
module plob_front #(
  parameter int NUM_LEVELS  = 1024,
  parameter int ORDER_SLOTS = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  plob_in_if.sink         in_ch,
  input  logic [31:0]     lowest_price,
  input  logic            busy,
  output logic            push_valid,
  input  logic            push_ready,
  output plob_pkg::cmd_t  push_cmd
);

  logic           valid_r, valid_nxt;
  plob_pkg::cmd_t cmd_r, cmd_nxt;
  logic           accept;
  logic [31:0]    diff;

  // Decode the word into a command with its checks already worked out.
  always_comb begin
    diff             = in_ch.price - lowest_price;
    cmd_nxt.func     = in_ch.func;
    cmd_nxt.order_id = in_ch.order_id;
    cmd_nxt.id_ok    = {5'd0, in_ch.order_id} < 17'(ORDER_SLOTS);
    cmd_nxt.side     = in_ch.side;
    cmd_nxt.lvl      = diff[plob_pkg::LVL_MAXW-1:0];
    cmd_nxt.in_range = {1'b0, diff} < 33'(NUM_LEVELS);
    cmd_nxt.qty_zero = (in_ch.quantity == 24'd0);
    cmd_nxt.qty      = in_ch.quantity;
  end

  assign in_ch.ready = !busy && (!valid_r || push_ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = valid_r;
  assign push_cmd    = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ----- design/plob_queue.sv -----
`timescale 1ns / 1ps
module plob_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  plob_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop,
  output plob_pkg::cmd_t pop_cmd
);

  plob_pkg::cmd_t ent_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = ent_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ----- design/plob_back.sv -----
`timescale 1ns / 1ps
module plob_back #(
  parameter int NUM_LEVELS  = 1024,
  parameter int ORDER_SLOTS = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    lowest_price,
  output logic           busy,
  input  logic           q_valid,
  output logic           q_pop,
  input  plob_pkg::cmd_t q_cmd,
  plob_out_if.source     out_ch
);

  localparam int LW    = $clog2(NUM_LEVELS);
  localparam int IW    = $clog2(ORDER_SLOTS);
  localparam int CLR_N = (ORDER_SLOTS > NUM_LEVELS) ? ORDER_SLOTS : NUM_LEVELS;
  localparam int CW    = $clog2(CLR_N);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_ADD  = 4'd3;
  localparam logic [3:0] S_RED  = 4'd4;
  localparam logic [3:0] S_REM  = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_PRD  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  typedef struct packed {
    logic          vld;
    logic          side;
    logic [LW-1:0] lvl;
    logic [23:0]   qty;
  } ent_t;

  ent_t        otab [ORDER_SLOTS];
  logic [35:0] bid_tot [NUM_LEVELS];
  logic [35:0] ask_tot [NUM_LEVELS];

  logic          ot_we;
  logic [IW-1:0] ot_waddr, ot_raddr;
  ent_t          ot_wdata, ot_rd;
  logic          b_we, a_we;
  logic [LW-1:0] lv_waddr, b_raddr, a_raddr, rd_addr;
  logic [35:0]   lv_wdata, b_rd, a_rd, tot_rd, tot_new;

  logic [3:0]     state_r, state_nxt;
  logic [CW-1:0]  clr_r, clr_nxt;
  plob_pkg::cmd_t cmd_r, cmd_nxt;
  ent_t           e_r, e_nxt;
  logic           ok_r, ok_nxt, sd_r, sd_nxt;
  logic [LW-1:0]  lvl_r, lvl_nxt, ptr_r, ptr_nxt;
  logic           bid_ok_r, bid_ok_nxt, ask_ok_r, ask_ok_nxt;
  logic [LW-1:0]  bid_best_r, bid_best_nxt, ask_best_r, ask_best_nxt;
  logic [35:0]    bid_sum_r, bid_sum_nxt, ask_sum_r, ask_sum_nxt;
  logic [23:0]    diff;
  logic [LW-1:0]  cmd_lvl;
  logic           reject, load;
  logic [3:0]     after_rem;

  logic        out_valid_r, out_valid_nxt;
  logic        o_ok_r, o_bv_r, o_av_r;
  logic [31:0] o_bp_r, o_ap_r;
  logic [35:0] o_bq_r, o_aq_r, o_bs_r, o_as_r;

  assign busy    = (state_r == S_CLR);
  assign tot_rd  = sd_r ? a_rd : b_rd;
  assign cmd_lvl = cmd_r.lvl[LW-1:0];
  assign load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
  assign after_rem = (cmd_r.func == plob_pkg::FN_MODIFY) ? S_PRD : S_FIN;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    cmd_nxt      = cmd_r;
    e_nxt        = e_r;
    ok_nxt       = ok_r;
    sd_nxt       = sd_r;
    lvl_nxt      = lvl_r;
    ptr_nxt      = ptr_r;
    bid_ok_nxt   = bid_ok_r;
    ask_ok_nxt   = ask_ok_r;
    bid_best_nxt = bid_best_r;
    ask_best_nxt = ask_best_r;
    bid_sum_nxt  = bid_sum_r;
    ask_sum_nxt  = ask_sum_r;
    q_pop        = 1'b0;
    ot_we        = 1'b0;
    ot_waddr     = IW'(cmd_r.order_id);
    ot_wdata     = e_r;
    ot_raddr     = IW'(q_cmd.order_id);
    b_we         = 1'b0;
    a_we         = 1'b0;
    lv_waddr     = lvl_r;
    lv_wdata     = '0;
    rd_addr      = lvl_r;
    b_raddr      = rd_addr;
    a_raddr      = rd_addr;
    reject       = 1'b0;
    tot_new      = '0;
    diff         = e_r.qty - cmd_r.qty;

    unique case (state_r)
      S_CLR: begin
        ot_we    = {1'b0, clr_r} < (CW+1)'(ORDER_SLOTS);
        ot_waddr = clr_r[IW-1:0];
        ot_wdata = '0;
        b_we     = {1'b0, clr_r} < (CW+1)'(NUM_LEVELS);
        a_we     = b_we;
        lv_waddr = clr_r[LW-1:0];
        if (clr_r == CW'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        e_nxt  = ot_rd;
        ok_nxt = 1'b1;
        case (cmd_r.func)
          plob_pkg::FN_ADD: begin
            reject = !cmd_r.id_ok || ot_rd.vld || cmd_r.qty_zero || !cmd_r.in_range;
            sd_nxt = cmd_r.side;
            lvl_nxt = cmd_lvl;
            state_nxt = S_ADD;
          end
          plob_pkg::FN_CANCEL: begin
            reject = !cmd_r.id_ok || !ot_rd.vld;
            sd_nxt = ot_rd.side;
            lvl_nxt = ot_rd.lvl;
            state_nxt = S_REM;
          end
          plob_pkg::FN_MODIFY: begin
            reject = !cmd_r.id_ok || !ot_rd.vld || cmd_r.qty_zero || !cmd_r.in_range;
            sd_nxt = ot_rd.side;
            if (cmd_lvl == ot_rd.lvl && cmd_r.qty <= ot_rd.qty) begin
              lvl_nxt   = cmd_lvl;
              state_nxt = S_RED;
            end else begin
              lvl_nxt   = ot_rd.lvl;
              state_nxt = S_REM;
            end
          end
          default: reject = 1'b1;
        endcase
        rd_addr = lvl_nxt;
        b_raddr = rd_addr;
        a_raddr = rd_addr;
        if (reject) begin
          ok_nxt    = 1'b0;
          state_nxt = S_FIN;
        end
      end
      S_ADD: begin
        tot_new  = tot_rd + 36'(cmd_r.qty);
        lv_wdata = tot_new;
        b_we     = !sd_r;
        a_we     = sd_r;
        ot_we    = 1'b1;
        ot_wdata = '{vld: 1'b1, side: sd_r, lvl: lvl_r, qty: cmd_r.qty};
        if (!sd_r) begin
          bid_sum_nxt = bid_sum_r + 36'(cmd_r.qty);
          if (!bid_ok_r || lvl_r > bid_best_r) begin
            bid_ok_nxt   = 1'b1;
            bid_best_nxt = lvl_r;
          end
        end else begin
          ask_sum_nxt = ask_sum_r + 36'(cmd_r.qty);
          if (!ask_ok_r || lvl_r < ask_best_r) begin
            ask_ok_nxt   = 1'b1;
            ask_best_nxt = lvl_r;
          end
        end
        state_nxt = S_FIN;
      end
      S_RED: begin
        lv_wdata = tot_rd - 36'(diff);
        b_we     = !sd_r;
        a_we     = sd_r;
        ot_we    = 1'b1;
        ot_wdata = '{vld: 1'b1, side: e_r.side, lvl: e_r.lvl, qty: cmd_r.qty};
        if (!sd_r) begin
          bid_sum_nxt = bid_sum_r - 36'(diff);
        end else begin
          ask_sum_nxt = ask_sum_r - 36'(diff);
        end
        state_nxt = S_FIN;
      end
      S_REM: begin
        tot_new  = tot_rd - 36'(e_r.qty);
        lv_wdata = tot_new;
        b_we     = !sd_r;
        a_we     = sd_r;
        ot_we    = 1'b1;
        ot_wdata = '{vld: 1'b0, side: e_r.side, lvl: e_r.lvl, qty: e_r.qty};
        state_nxt = after_rem;
        if (!sd_r) begin
          bid_sum_nxt = bid_sum_r - 36'(e_r.qty);
          if (tot_new == 36'd0 && bid_ok_r && bid_best_r == lvl_r) begin
            bid_ok_nxt = 1'b0;
            if (lvl_r != '0) begin
              ptr_nxt   = lvl_r - 1'b1;
              state_nxt = S_SCAN;
            end
          end
        end else begin
          ask_sum_nxt = ask_sum_r - 36'(e_r.qty);
          if (tot_new == 36'd0 && ask_ok_r && ask_best_r == lvl_r) begin
            ask_ok_nxt = 1'b0;
            if (lvl_r != LW'(NUM_LEVELS - 1)) begin
              ptr_nxt   = lvl_r + 1'b1;
              state_nxt = S_SCAN;
            end
          end
        end
        rd_addr = ptr_nxt;
        b_raddr = rd_addr;
        a_raddr = rd_addr;
      end
      S_SCAN: begin
        if (tot_rd != 36'd0) begin
          if (!sd_r) begin
            bid_ok_nxt   = 1'b1;
            bid_best_nxt = ptr_r;
          end else begin
            ask_ok_nxt   = 1'b1;
            ask_best_nxt = ptr_r;
          end
          state_nxt = after_rem;
        end else if ((!sd_r && ptr_r == '0) ||
                     (sd_r && ptr_r == LW'(NUM_LEVELS - 1))) begin
          state_nxt = after_rem;
        end else begin
          ptr_nxt = sd_r ? ptr_r + 1'b1 : ptr_r - 1'b1;
        end
        rd_addr = ptr_nxt;
        b_raddr = rd_addr;
        a_raddr = rd_addr;
      end
      S_PRD: begin
        lvl_nxt   = cmd_lvl;
        rd_addr   = cmd_lvl;
        b_raddr   = rd_addr;
        a_raddr   = rd_addr;
        state_nxt = S_ADD;
      end
      S_FIN: begin
        b_raddr   = bid_best_r;
        a_raddr   = ask_best_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        b_raddr = bid_best_r;
        a_raddr = ask_best_r;
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      bid_ok_r    <= 1'b0;
      ask_ok_r    <= 1'b0;
      bid_best_r  <= '0;
      ask_best_r  <= '0;
      bid_sum_r   <= '0;
      ask_sum_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      bid_ok_r    <= bid_ok_nxt;
      ask_ok_r    <= ask_ok_nxt;
      bid_best_r  <= bid_best_nxt;
      ask_best_r  <= ask_best_nxt;
      bid_sum_r   <= bid_sum_nxt;
      ask_sum_r   <= ask_sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    e_r   <= e_nxt;
    ok_r  <= ok_nxt;
    sd_r  <= sd_nxt;
    lvl_r <= lvl_nxt;
    ptr_r <= ptr_nxt;
    if (load) begin
      o_ok_r <= ok_r;
      o_bv_r <= bid_ok_r;
      o_av_r <= ask_ok_r;
      o_bp_r <= bid_ok_r ? lowest_price + 32'(bid_best_r) : 32'd0;
      o_ap_r <= ask_ok_r ? lowest_price + 32'(ask_best_r) : 32'd0;
      o_bq_r <= bid_ok_r ? b_rd : 36'd0;
      o_aq_r <= ask_ok_r ? a_rd : 36'd0;
      o_bs_r <= bid_sum_r;
      o_as_r <= ask_sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ot_we) begin
      otab[ot_waddr] <= ot_wdata;
    end
    ot_rd <= otab[ot_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bid_tot[lv_waddr] <= lv_wdata;
    end
    b_rd <= bid_tot[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      ask_tot[lv_waddr] <= lv_wdata;
    end
    a_rd <= ask_tot[a_raddr];
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.ok                = o_ok_r;
  assign out_ch.bid_valid         = o_bv_r;
  assign out_ch.best_bid_price    = o_bp_r;
  assign out_ch.best_bid_quantity = o_bq_r;
  assign out_ch.ask_valid         = o_av_r;
  assign out_ch.best_ask_price    = o_ap_r;
  assign out_ch.best_ask_quantity = o_aq_r;
  assign out_ch.bid_side_shares   = o_bs_r;
  assign out_ch.ask_side_shares   = o_as_r;

  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result register loaded outside the output step");

  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> $past(state_r) == S_REM || $past(state_r) == S_SCAN)
    else $error("level search entered without a removal");

  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && $past(state_r) != S_OUT) |-> $past(state_r) == S_FIN)
    else $error("output step reached without reading the best levels");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !q_pop && !out_valid_r)
    else $error("work started during the clearing pass");

endmodule

// ----- design/price_level_order_book.sv -----
`timescale 1ns / 1ps
// Each accepted word is registered in the front end and queued; the back end then checks it
// against the order table and applies it as an add, a cancel or a reduce. A rejected word
// skips the update, a modify that moves or raises its order is removed and added anew, and
// a cancel or move that empties the best level adds a search level by level. The back end
// works on one word at a time, for the read-modify-write of the order table and level totals.
// Reset (synchronous, rst_n low) clears control state, then a clearing pass over
// max(ORDER_SLOTS, NUM_LEVELS) entries runs with no word accepted.
module price_level_order_book #(
  parameter int NUM_LEVELS  = 1024,
  parameter int ORDER_SLOTS = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  plob_in_if.sink                     in_ch,
  plob_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [plob_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  // The single configuration register places level zero of the book at a price.
  // Resting orders keep their level index, so a new value moves their prices too.
  logic [31:0] lowest_price_r, lowest_price_nxt;
  logic        cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == plob_pkg::REG_LOWEST_PRICE);
  assign cfg_prdata = cfg_hit ? lowest_price_r : 32'd0;

  always_comb begin
    lowest_price_nxt = lowest_price_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      lowest_price_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_price_r <= 32'd0;
    end else begin
      lowest_price_r <= lowest_price_nxt;
    end
  end

  // The front end takes each word, works out its level index and range checks,
  // and hands a command to a two-entry queue so that it keeps taking words while
  // the back end is busy with a search or waits on a stalled result.
  logic           busy;
  logic           push_valid, push_ready, pop_valid, pop;
  plob_pkg::cmd_t push_cmd, pop_cmd;

  plob_front #(
    .NUM_LEVELS (NUM_LEVELS),
    .ORDER_SLOTS(ORDER_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .lowest_price(lowest_price_r),
    .busy        (busy),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  plob_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_cmd   (pop_cmd)
  );

  // The back end owns the order table and level totals, applies each command,
  // searches outward for a new best level when one empties, and registers the
  // result so that the next command may start while the result waits.
  plob_back #(
    .NUM_LEVELS (NUM_LEVELS),
    .ORDER_SLOTS(ORDER_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .lowest_price(lowest_price_r),
    .busy        (busy),
    .q_valid     (pop_valid),
    .q_pop       (pop),
    .q_cmd       (pop_cmd),
    .out_ch      (out_ch)
  );

endmodule
